### design/alte_pkg.sv
`default_nettype none

package alte_pkg;

  // Fixed field widths of the command and result beats
  localparam int KIND_W   = 3;
  localparam int POS_W    = 9;
  localparam int VAL_W    = 32;
  localparam int STATUS_W = 3;
  localparam int FPOS_W   = 8;
  localparam int LEN_W    = 9;
  localparam int CAP_W    = 9;

  // Register port
  localparam int APB_AW = 3;
  localparam int APB_DW = 32;

  localparam logic [CAP_W-1:0] CAP_RESET = 9'd256;

  typedef enum logic [KIND_W-1:0] {
    KIND_INSERT = 3'd0,
    KIND_REMOVE = 3'd1,
    KIND_READ   = 3'd2,
    KIND_WRITE  = 3'd3,
    KIND_FIND   = 3'd4,
    KIND_CLEAR  = 3'd5
  } kind_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 3'd0,
    ST_FULL     = 3'd1,
    ST_BADPOS   = 3'd2,
    ST_EMPTY    = 3'd3,
    ST_NOTFOUND = 3'd4
  } status_e;

endpackage

`default_nettype wire

### design/array_list_table_engine_top.sv
`default_nettype none

// Bounded sequential list engine.
// Commands arrive as beats on the in channel (kind, position, value) with
// valid/ready; each command yields exactly one result beat on the out channel
// (status, read_value, found_position, length).
// One command is worked on at a time; in_ready_o is high while the engine is
// idle, even while the previous result still waits in the output register.
// From acceptance to result valid, bound by the list memory (one read and one
// write per cycle), each command passes an execute state, then these steps:
//   read                          : one registered memory read
//   write, clear, unused kinds, insert at the end, failures: no further step
//   insert at position p below length: entries p..length-1 move up, then put
//   remove at position p          : entries above p move down one place
//   find                          : entries from 0 up to a hit or the last one
// Each result then waits in a done state until the output register is free.
// The next command can be taken in the cycle after the result is loaded.
// Capacity is register 0 of the APB-style port, to be written only while idle; the block itself does not enforce this.
// Reset clears the entry count, the capacity back to 256 and all handshake
// state; memory contents are not cleared. A stalled receiver holds the result
// in the output register; a finished command behind it waits until it frees.
module array_list_table_engine_top #(
  parameter int DEPTH      = 256,
  parameter int DATA_WIDTH = 32
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // command channel
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [alte_pkg::KIND_W-1:0]   kind_i,
  input  wire logic [alte_pkg::POS_W-1:0]    position_i,
  input  wire logic [alte_pkg::VAL_W-1:0]    value_i,
  // result channel
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic [alte_pkg::STATUS_W-1:0]      status_o,
  output logic [alte_pkg::VAL_W-1:0]         read_value_o,
  output logic [alte_pkg::FPOS_W-1:0]        found_position_o,
  output logic [alte_pkg::LEN_W-1:0]         length_o,
  // register port
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [alte_pkg::APB_AW-1:0]   paddr,
  input  wire logic [alte_pkg::APB_DW-1:0]   pwdata,
  output logic [alte_pkg::APB_DW-1:0]        prdata,
  output logic                               pready
);
  import alte_pkg::*;

  localparam int AW   = $clog2(DEPTH);
  localparam int CW   = $clog2(DEPTH + 1);
  localparam int CMPW = (CW > POS_W) ? CW : POS_W;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EXEC = 3'd1;
  localparam logic [2:0] S_INS  = 3'd2;
  localparam logic [2:0] S_PUT  = 3'd3;
  localparam logic [2:0] S_REM  = 3'd4;
  localparam logic [2:0] S_RD   = 3'd5;
  localparam logic [2:0] S_FIND = 3'd6;
  localparam logic [2:0] S_DONE = 3'd7;

  // ---------------------------------------------------------------------------
  // Register port
  logic             cap_wr;
  logic [CAP_W-1:0] cap_q;

  assign pready = 1'b1;
  assign cap_wr = psel && penable && pwrite && (paddr == '0);
  assign prdata = (paddr == '0) ? {{(APB_DW-CAP_W){1'b0}}, cap_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CAP_RESET;
    end else if (cap_wr) begin
      cap_q <= pwdata[CAP_W-1:0];
    end
  end

  // ---------------------------------------------------------------------------
  // List memory: one write and one registered read per cycle
  logic [DATA_WIDTH-1:0] mem [DEPTH];
  logic                  we;
  logic [AW-1:0]         waddr;
  logic [DATA_WIDTH-1:0] wdata;
  logic [AW-1:0]         raddr;
  logic [DATA_WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_q <= mem[raddr];
  end

  // ---------------------------------------------------------------------------
  // Sequencer state
  logic [2:0]            state_q, state_d;
  logic [CW-1:0]         cnt_q, cnt_d;
  logic [AW-1:0]         ptr_q, ptr_d;
  logic [KIND_W-1:0]     kind_q;
  logic [POS_W-1:0]      pos_q;
  logic [DATA_WIDTH-1:0] val_q;
  logic [STATUS_W-1:0]   res_st_q, res_st_d;
  logic [VAL_W-1:0]      res_rd_q, res_rd_d;
  logic [FPOS_W-1:0]     res_fp_q, res_fp_d;

  logic                  in_acc;
  logic                  out_free;
  logic [DATA_WIDTH+VAL_W-1:0] val_wide;
  logic [DATA_WIDTH+VAL_W-1:0] rd_wide;
  logic [CMPW-1:0]       cnt_ext, cnt_m1, pos_ext, cap_ext, ptr_ext;
  logic                  full;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_o || out_ready_i;

  // values are kept to DATA_WIDTH bits
  assign val_wide = {{DATA_WIDTH{1'b0}}, value_i};
  assign rd_wide  = {{VAL_W{1'b0}}, rdata_q};

  assign cnt_ext = CMPW'(cnt_q);
  assign cnt_m1  = cnt_ext - CMPW'(1);
  assign pos_ext = CMPW'(pos_q);
  assign cap_ext = CMPW'(cap_q);
  assign ptr_ext = CMPW'(ptr_q);
  assign full    = (cnt_ext >= cap_ext) || (cnt_ext >= CMPW'(DEPTH));

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      kind_q <= kind_i;
      pos_q  <= position_i;
      val_q  <= val_wide[DATA_WIDTH-1:0];
    end
    ptr_q    <= ptr_d;
    res_st_q <= res_st_d;
    res_rd_q <= res_rd_d;
    res_fp_q <= res_fp_d;
  end

  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    ptr_d    = ptr_q;
    res_st_d = res_st_q;
    res_rd_d = res_rd_q;
    res_fp_d = res_fp_q;
    we       = 1'b0;
    waddr    = pos_ext[AW-1:0];
    wdata    = val_q;
    raddr    = ptr_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          state_d = S_EXEC;
        end
      end

      S_EXEC: begin
        res_st_d = ST_OK;
        res_rd_d = '0;
        res_fp_d = '0;
        state_d  = S_DONE;
        unique case (kind_e'(kind_q))
          KIND_INSERT: begin
            if (full) begin
              res_st_d = ST_FULL;
            end else if (pos_ext > cnt_ext) begin
              res_st_d = ST_BADPOS;
            end else if (pos_ext == cnt_ext) begin
              we    = 1'b1;
              cnt_d = cnt_q + CW'(1);
            end else begin
              // move entries up, from the top down to position
              raddr   = cnt_m1[AW-1:0];
              ptr_d   = cnt_m1[AW-1:0];
              state_d = S_INS;
            end
          end
          KIND_REMOVE: begin
            if (cnt_q == '0) begin
              res_st_d = ST_EMPTY;
            end else if (pos_ext >= cnt_ext) begin
              res_st_d = ST_BADPOS;
            end else if (pos_ext == cnt_m1) begin
              cnt_d = cnt_q - CW'(1);
            end else begin
              raddr   = pos_ext[AW-1:0] + AW'(1);
              ptr_d   = pos_ext[AW-1:0] + AW'(1);
              state_d = S_REM;
            end
          end
          KIND_READ: begin
            if (pos_ext >= cnt_ext) begin
              res_st_d = ST_BADPOS;
            end else begin
              raddr   = pos_ext[AW-1:0];
              state_d = S_RD;
            end
          end
          KIND_WRITE: begin
            if (pos_ext >= cnt_ext) begin
              res_st_d = ST_BADPOS;
            end else begin
              we = 1'b1;
            end
          end
          KIND_FIND: begin
            if (cnt_q == '0) begin
              res_st_d = ST_NOTFOUND;
            end else begin
              raddr   = '0;
              ptr_d   = '0;
              state_d = S_FIND;
            end
          end
          KIND_CLEAR: begin
            cnt_d = '0;
          end
          default: begin
          end
        endcase
      end

      S_INS: begin
        // rdata_q holds entry ptr, read last cycle
        we    = 1'b1;
        waddr = ptr_q + AW'(1);
        wdata = rdata_q;
        if (ptr_ext == pos_ext) begin
          state_d = S_PUT;
        end else begin
          raddr = ptr_q - AW'(1);
          ptr_d = ptr_q - AW'(1);
        end
      end

      S_PUT: begin
        we      = 1'b1;
        cnt_d   = cnt_q + CW'(1);
        state_d = S_DONE;
      end

      S_REM: begin
        we    = 1'b1;
        waddr = ptr_q - AW'(1);
        wdata = rdata_q;
        if (ptr_ext == cnt_m1) begin
          cnt_d   = cnt_q - CW'(1);
          state_d = S_DONE;
        end else begin
          raddr = ptr_q + AW'(1);
          ptr_d = ptr_q + AW'(1);
        end
      end

      S_RD: begin
        res_rd_d = rd_wide[VAL_W-1:0];
        state_d  = S_DONE;
      end

      S_FIND: begin
        if (rdata_q == val_q) begin
          res_st_d = ST_OK;
          res_fp_d = ptr_ext[FPOS_W-1:0];
          state_d  = S_DONE;
        end else if (ptr_ext == cnt_m1) begin
          res_st_d = ST_NOTFOUND;
          state_d  = S_DONE;
        end else begin
          raddr = ptr_q + AW'(1);
          ptr_d = ptr_q + AW'(1);
        end
      end

      S_DONE: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Output register
  logic out_valid_q;
  logic out_load;

  assign out_load    = (state_q == S_DONE) && out_free;
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      status_o         <= res_st_q;
      read_value_o     <= res_rd_q;
      found_position_o <= res_fp_q;
      length_o         <= cnt_ext[LEN_W-1:0];
    end
  end

endmodule

`default_nettype wire
